// ----- sv/rie_pkg.sv -----
// ----------------------------------------------------------------------------
// RISC instruction executor package
// Shared constants, opcodes, fault codes and payload types of the executor.
// ----------------------------------------------------------------------------
package rie_pkg;

   localparam int DATA_W       = 32;
   localparam int OPC_W        = 4;
   localparam int RFIELD_W     = 5;
   localparam int MADDR_OUT_W  = 11;
   localparam int FAULT_W      = 2;
   localparam int DIV_CNT_W    = $clog2(DATA_W);

   localparam int NUM_REGS_DEF  = 32;
   localparam int MEM_WORDS_DEF = 2048;

   // Opcodes.
   localparam logic [OPC_W-1:0] OP_ADD  = 4'd0;
   localparam logic [OPC_W-1:0] OP_ADDI = 4'd1;
   localparam logic [OPC_W-1:0] OP_SUB  = 4'd2;
   localparam logic [OPC_W-1:0] OP_SUBI = 4'd3;
   localparam logic [OPC_W-1:0] OP_MUL  = 4'd4;
   localparam logic [OPC_W-1:0] OP_DIV  = 4'd5;
   localparam logic [OPC_W-1:0] OP_BLT  = 4'd6;
   localparam logic [OPC_W-1:0] OP_BGT  = 4'd7;
   localparam logic [OPC_W-1:0] OP_BEQ  = 4'd8;
   localparam logic [OPC_W-1:0] OP_J    = 4'd9;
   localparam logic [OPC_W-1:0] OP_JR   = 4'd10;
   localparam logic [OPC_W-1:0] OP_JAL  = 4'd11;
   localparam logic [OPC_W-1:0] OP_LW   = 4'd12;
   localparam logic [OPC_W-1:0] OP_SW   = 4'd13;
   localparam logic [OPC_W-1:0] OP_MOV  = 4'd14;
   localparam logic [OPC_W-1:0] OP_MOVI = 4'd15;

   // Fault codes.
   localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_DIV0 = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_ADDR = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0]        next_pc;
      logic                     reg_write_en;
      logic [RFIELD_W-1:0]      reg_write_idx;
      logic signed [DATA_W-1:0] reg_write_val;
      logic                     mem_write_en;
      logic [MADDR_OUT_W-1:0]   mem_write_addr;
      logic signed [DATA_W-1:0] mem_write_val;
      logic [DATA_W-1:0]        return_addr;
      logic [FAULT_W-1:0]       fault;
   } rsp_payload_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- sv/rie_req_if.sv -----
// ----------------------------------------------------------------------------
// Executor request channel
// Valid/ready channel that carries one decoded instruction per request.
// ----------------------------------------------------------------------------
interface rie_req_if;

   logic                             valid;
   logic                             ready;
   logic [rie_pkg::OPC_W-1:0]        req_type;
   logic [rie_pkg::RFIELD_W-1:0]     dest_reg;
   logic [rie_pkg::RFIELD_W-1:0]     src_reg_a;
   logic [rie_pkg::RFIELD_W-1:0]     src_reg_b;
   logic signed [rie_pkg::DATA_W-1:0] immediate;

   modport source (
      output valid, req_type, dest_reg, src_reg_a, src_reg_b, immediate,
      input  ready
   );

   modport sink (
      input  valid, req_type, dest_reg, src_reg_a, src_reg_b, immediate,
      output ready
   );

endinterface

// ----- sv/rie_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Executor result channel
// Valid/ready channel that carries the outcome of one executed instruction.
// ----------------------------------------------------------------------------
interface rie_rsp_if;

   logic                                  valid;
   logic                                  ready;
   logic [rie_pkg::DATA_W-1:0]            next_pc;
   logic                                  reg_write_en;
   logic [rie_pkg::RFIELD_W-1:0]          reg_write_idx;
   logic signed [rie_pkg::DATA_W-1:0]     reg_write_val;
   logic                                  mem_write_en;
   logic [rie_pkg::MADDR_OUT_W-1:0]       mem_write_addr;
   logic signed [rie_pkg::DATA_W-1:0]     mem_write_val;
   logic [rie_pkg::DATA_W-1:0]            return_addr;
   logic [rie_pkg::FAULT_W-1:0]           fault;

   modport source (
      output valid, next_pc, reg_write_en, reg_write_idx, reg_write_val,
             mem_write_en, mem_write_addr, mem_write_val, return_addr, fault,
      input  ready
   );

   modport sink (
      input  valid, next_pc, reg_write_en, reg_write_idx, reg_write_val,
             mem_write_en, mem_write_addr, mem_write_val, return_addr, fault,
      output ready
   );

endinterface

// ----- sv/risc_instruction_executor.sv -----
// ----------------------------------------------------------------------------
// RISC instruction executor
// Executes one decoded MIPS-like instruction per request against a register
// file, a word-addressed data memory, a program counter and a link register.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Carries
//   req_chan   in         one decoded instruction (opcode, registers, immediate)
//   rsp_chan   out        next PC, register/memory write, link register, fault
//
// Most instructions are accepted in IDLE, where the register file is read, and
// then execute and commit in EXEC. A load adds a LOAD state because the data
// memory read is registered. A divide waits in DIV for the iterative
// divider that produces one quotient bit per cycle.
// After reset the data memory is cleared one word per cycle, and no request is
// accepted until every word is cleared. The result sits in an output register;
// a new request is accepted while it waits, and that request stalls at its
// commit step until the previous result has been taken.
//
module risc_instruction_executor #(
   parameter int NUM_REGS  = rie_pkg::NUM_REGS_DEF,
   parameter int MEM_WORDS = rie_pkg::MEM_WORDS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   rie_req_if.sink   req_chan,
   rie_rsp_if.source rsp_chan
);

   localparam int W    = rie_pkg::DATA_W;
   localparam int RA_W = $clog2(NUM_REGS);
   localparam int DA_W = $clog2(MEM_WORDS);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;

   // Control state.
   logic [2:0]            state_ff, state_in;
   logic [DA_W-1:0]       clr_addr_ff;
   logic [W-1:0]          pc_ff;
   logic [W-1:0]          link_ff;
   logic [NUM_REGS-1:0]   rvalid_ff;
   logic                  rsp_valid_ff;

   // Latched request fields. Port B holds the jr source register for jr.
   logic [rie_pkg::OPC_W-1:0]    op_ff;
   logic [rie_pkg::RFIELD_W-1:0] rd_ff;
   logic [rie_pkg::RFIELD_W-1:0] ra_ff;
   logic [rie_pkg::RFIELD_W-1:0] rb_ff;
   logic [W-1:0]                 imm_ff;
   rie_pkg::rsp_payload_type     rsp_ff;

   logic                         req_ready;
   logic                         accept;
   logic                         out_free;
   logic                         commit;
   logic                         clr_last;

   // Register file read side.
   logic [rie_pkg::RFIELD_W-1:0] b_field;
   logic [W-1:0]                 ra_req_wide, rb_req_wide;
   logic [W-1:0]                 ra_wide, rb_wide, rd_wide;
   logic [RA_W-1:0]              ra_idx, rb_idx, rd_idx;
   logic                         ra_ok, rb_ok, rd_ok;
   logic [W-1:0]                 rf_a_data, rf_b_data;
   logic [W-1:0]                 va, vb;

   // Execute results.
   logic [W-1:0]                 pc1;
   logic [W-1:0]                 ea;
   logic                         ex_oob;
   logic [W-1:0]                 ex_npc;
   logic                         ex_wr;
   logic [W-1:0]                 ex_wval;
   logic                         ex_mw;
   logic [W-1:0]                 ex_link;
   logic [rie_pkg::FAULT_W-1:0]  ex_fault;
   logic [W-1:0]                 cm_wval;

   // Data memory and divider.
   logic                         dm_we, dm_re;
   logic [DA_W-1:0]              dm_waddr;
   logic [W-1:0]                 dm_wdata;
   logic [W-1:0]                 dm_rdata;
   logic                         div_start;
   rie_pkg::div_req_type         div_req;
   rie_pkg::div_rsp_type         div_rsp;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_chan.valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign clr_last  = (clr_addr_ff == DA_W'(MEM_WORDS - 1));

   // Register file addresses are presented straight from the request so the
   // operands are ready in the execute cycle. Indexes at or above NUM_REGS
   // read as zero and are never written.
   assign b_field     = (req_chan.req_type == rie_pkg::OP_JR) ? req_chan.dest_reg
                                                              : req_chan.src_reg_b;
   assign ra_req_wide = W'(req_chan.src_reg_a);
   assign rb_req_wide = W'(b_field);

   assign ra_wide = W'(ra_ff);
   assign rb_wide = W'(rb_ff);
   assign rd_wide = W'(rd_ff);
   assign ra_idx  = ra_wide[RA_W-1:0];
   assign rb_idx  = rb_wide[RA_W-1:0];
   assign rd_idx  = rd_wide[RA_W-1:0];
   assign ra_ok   = ra_wide < W'(NUM_REGS);
   assign rb_ok   = rb_wide < W'(NUM_REGS);
   assign rd_ok   = rd_wide < W'(NUM_REGS);

   // Two copies of the register file give two read ports; both are written
   // together at commit. Entries never written read as zero via the valid bits.
   rie_ram #(.WIDTH(W), .DEPTH(NUM_REGS)) u_rf_a (
      .clock   (clock),
      .wr_en   (commit && ex_wr),
      .wr_addr (rd_idx),
      .wr_data (cm_wval),
      .rd_en   (accept),
      .rd_addr (ra_req_wide[RA_W-1:0]),
      .rd_data (rf_a_data)
   );

   rie_ram #(.WIDTH(W), .DEPTH(NUM_REGS)) u_rf_b (
      .clock   (clock),
      .wr_en   (commit && ex_wr),
      .wr_addr (rd_idx),
      .wr_data (cm_wval),
      .rd_en   (accept),
      .rd_addr (rb_req_wide[RA_W-1:0]),
      .rd_data (rf_b_data)
   );

   assign va = (ra_ok && rvalid_ff[ra_idx]) ? rf_a_data : '0;
   assign vb = (rb_ok && rvalid_ff[rb_idx]) ? rf_b_data : '0;

   // A store uses the second register as its base, every other access the first.
   assign pc1    = pc_ff + W'(1);
   assign ea     = imm_ff + ((op_ff == rie_pkg::OP_SW) ? vb : va);
   assign ex_oob = ea >= W'(MEM_WORDS);

   // Instruction decode and execute.
   always_comb begin
      ex_npc   = pc1;
      ex_wr    = 1'b0;
      ex_wval  = '0;
      ex_mw    = 1'b0;
      ex_link  = link_ff;
      ex_fault = rie_pkg::FAULT_NONE;
      unique case (op_ff)
         rie_pkg::OP_ADD: begin
            ex_wr   = 1'b1;
            ex_wval = va + vb;
         end
         rie_pkg::OP_ADDI: begin
            ex_wr   = 1'b1;
            ex_wval = va + imm_ff;
         end
         rie_pkg::OP_SUB: begin
            ex_wr   = 1'b1;
            ex_wval = va - vb;
         end
         rie_pkg::OP_SUBI: begin
            ex_wr   = 1'b1;
            ex_wval = va - imm_ff;
         end
         rie_pkg::OP_MUL: begin
            ex_wr   = 1'b1;
            ex_wval = va * vb;
         end
         rie_pkg::OP_DIV: begin
            // The quotient itself comes from the divider at commit.
            if (vb == '0) begin
               ex_fault = rie_pkg::FAULT_DIV0;
            end else begin
               ex_wr = 1'b1;
            end
         end
         rie_pkg::OP_BLT: begin
            if ($signed(va) < $signed(vb)) begin
               ex_npc = imm_ff;
            end
         end
         rie_pkg::OP_BGT: begin
            if ($signed(vb) < $signed(va)) begin
               ex_npc = imm_ff;
            end
         end
         rie_pkg::OP_BEQ: begin
            if (va == vb) begin
               ex_npc = imm_ff;
            end
         end
         rie_pkg::OP_J: begin
            ex_npc = imm_ff;
         end
         rie_pkg::OP_JR: begin
            ex_npc = vb;
         end
         rie_pkg::OP_JAL: begin
            ex_link = pc1;
            ex_npc  = imm_ff;
         end
         rie_pkg::OP_LW: begin
            if (ex_oob) begin
               ex_fault = rie_pkg::FAULT_ADDR;
            end else begin
               ex_wr = 1'b1;
            end
         end
         rie_pkg::OP_SW: begin
            if (ex_oob) begin
               ex_fault = rie_pkg::FAULT_ADDR;
            end else begin
               ex_mw = 1'b1;
            end
         end
         rie_pkg::OP_MOV: begin
            ex_wr   = 1'b1;
            ex_wval = va;
         end
         rie_pkg::OP_MOVI: begin
            ex_wr   = 1'b1;
            ex_wval = imm_ff;
         end
         default: begin
            ex_wr = 1'b0;
         end
      endcase
      // Writes to a register beyond the file are dropped.
      if (!rd_ok) begin
         ex_wr = 1'b0;
      end
   end

   always_comb begin
      case (state_ff)
         ST_LOAD: cm_wval = dm_rdata;
         ST_DIV:  cm_wval = div_rsp.quotient;
         default: cm_wval = ex_wval;
      endcase
   end

   // Sequencer. Register file and link/PC updates all happen at commit, which
   // always precedes the next request's register read.
   always_comb begin
      state_in  = state_ff;
      commit    = 1'b0;
      dm_re     = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if ((op_ff == rie_pkg::OP_LW) && !ex_oob) begin
               dm_re    = 1'b1;
               state_in = ST_LOAD;
            end else if ((op_ff == rie_pkg::OP_DIV) && (vb != '0)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else if (out_free) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_rsp.done && out_free) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign div_req = '{start: div_start, dividend: va, divisor: vb};

   rie_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Data memory: the clearing pass and stores share the write port.
   assign dm_we    = (state_ff == ST_CLEAR) || (commit && ex_mw);
   assign dm_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : ea[DA_W-1:0];
   assign dm_wdata = (state_ff == ST_CLEAR) ? '0 : va;

   rie_ram #(.WIDTH(W), .DEPTH(MEM_WORDS)) u_dmem (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_en   (dm_re),
      .rd_addr (ea[DA_W-1:0]),
      .rd_data (dm_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         pc_ff        <= '0;
         link_ff      <= '0;
         rvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + DA_W'(1);
         end
         if (commit) begin
            pc_ff        <= ex_npc;
            link_ff      <= ex_link;
            rsp_valid_ff <= 1'b1;
            if (ex_wr) begin
               rvalid_ff[rd_idx] <= 1'b1;
            end
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request fields and the result payload carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_chan.req_type;
         rd_ff  <= req_chan.dest_reg;
         ra_ff  <= req_chan.src_reg_a;
         rb_ff  <= b_field;
         imm_ff <= req_chan.immediate;
      end
      if (commit) begin
         rsp_ff.next_pc        <= ex_npc;
         rsp_ff.reg_write_en   <= ex_wr;
         rsp_ff.reg_write_idx  <= ex_wr ? rd_ff : '0;
         rsp_ff.reg_write_val  <= ex_wr ? cm_wval : '0;
         rsp_ff.mem_write_en   <= ex_mw;
         rsp_ff.mem_write_addr <= ex_mw ? ea[rie_pkg::MADDR_OUT_W-1:0] : '0;
         rsp_ff.mem_write_val  <= ex_mw ? va : '0;
         rsp_ff.return_addr    <= ex_link;
         rsp_ff.fault          <= ex_fault;
      end
   end

   assign req_chan.ready          = req_ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.next_pc        = rsp_ff.next_pc;
   assign rsp_chan.reg_write_en   = rsp_ff.reg_write_en;
   assign rsp_chan.reg_write_idx  = rsp_ff.reg_write_idx;
   assign rsp_chan.reg_write_val  = rsp_ff.reg_write_val;
   assign rsp_chan.mem_write_en   = rsp_ff.mem_write_en;
   assign rsp_chan.mem_write_addr = rsp_ff.mem_write_addr;
   assign rsp_chan.mem_write_val  = rsp_ff.mem_write_val;
   assign rsp_chan.return_addr    = rsp_ff.return_addr;
   assign rsp_chan.fault          = rsp_ff.fault;

endmodule

// ----- sv/rie_ram.sv -----
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rie_ram #(
   parameter int WIDTH = rie_pkg::DATA_W,
   parameter int DEPTH = rie_pkg::NUM_REGS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/rie_div.sv -----
// ----------------------------------------------------------------------------
// Iterative signed divider
// Restoring radix-2 divide on magnitudes, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module rie_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rie_pkg::div_req_type div_req,
   output rie_pkg::div_rsp_type div_rsp
);

   localparam int W = rie_pkg::DATA_W;

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic                            neg_ff, neg_in;
   logic [W-1:0]                    dsr_ff, dsr_in;
   logic [W-1:0]                    rem_ff, rem_in;
   logic [W-1:0]                    quo_ff, quo_in;
   logic [rie_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [W:0]                      trial;

   // Shift in the next dividend bit and try to subtract the divisor.
   assign trial = {rem_ff, quo_ff[W-1]} - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      neg_in  = neg_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         neg_in  = div_req.dividend[W-1] ^ div_req.divisor[W-1];
         quo_in  = div_req.dividend[W-1] ? (W'(0) - div_req.dividend) : div_req.dividend;
         dsr_in  = div_req.divisor[W-1] ? (W'(0) - div_req.divisor) : div_req.divisor;
         rem_in  = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rie_pkg::DIV_CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? (W'(0) - quo_ff) : quo_ff;

endmodule
